@@ hdl/nit_pkg.sv @@
// package: sizes, payload structs and controller states of the name interning table
package nit_pkg;

    localparam int STORE_BYTES  = 1024;
    localparam int MAX_NAMES    = 64;
    localparam int MAX_NAME_LEN = 32;

    localparam int SA_W  = $clog2(STORE_BYTES);      // store address
    localparam int FP_W  = SA_W + 1;                 // free pointer
    localparam int ID_W  = 7;                        // field width of ids
    localparam int NS_D  = MAX_NAMES + 1;            // start table depth
    localparam int NS_AW = $clog2(NS_D);
    localparam int PB_AW = $clog2(MAX_NAME_LEN);     // pending buffer address
    localparam int PL_W  = PB_AW + 1;                // pending length

    localparam logic [1:0] ST_NEW      = 2'd0;
    localparam logic [1:0] ST_EXISTING = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADID    = 2'd3;

    localparam logic FN_INTERN = 1'b0;
    localparam logic FN_READ   = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] char_in;
        logic       char_last;
        logic [6:0] name_id;
    } t_item_in;

    typedef struct packed {
        logic [6:0] result_id;
        logic [7:0] char_out;
        logic       out_last;
        logic [1:0] status;
    } t_item_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NS0,
        S_NS1,
        S_NS2,
        S_CC0,
        S_CC1,
        S_ALLOC,
        S_CP0,
        S_CP1,
        S_TERM,
        S_RC0,
        S_RC1
    } t_state;

endpackage

@@ hdl/name_interning_table_unit.sv @@
// top level: name interning table controller with its three memories
//
// Names are interned one character per beat (func intern); the beat that carries the
// last mark starts a search over stored names 1..count and answers with one result beat:
// the existing id, a newly assigned id, or id 0 with status full. A read beat (func read)
// answers with one beat per stored character, the last one marked, or a single bad-id
// beat. Results appear for exactly one cycle on o_result with o_strobe high and cannot
// be held off. A non-last intern character is taken in and busy stays low. A last
// character reads the start table for each stored name visited (S_NS0 to S_NS2) and,
// where the lengths match, compares the characters in pairs (S_CC0, S_CC1); a new name
// then passes S_ALLOC and copies each character into the store (S_CP0, S_CP1), and
// S_TERM writes the zero byte. A read visits the start table, then each character
// (S_RC0, S_RC1); all reads are registered. No clearing pass is needed after reset.
module name_interning_table_unit
    import nit_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_item_in  i_item,
    output logic      o_strobe,
    output t_item_out o_result
);
    // controller state
    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_count, n_count;    // names stored
    logic [FP_W-1:0]    r_free,  n_free;     // first unused store byte
    logic [PL_W-1:0]    r_plen,  n_plen;     // pending name length
    logic               r_ovf,   n_ovf;      // pending name too long
    logic [ID_W-1:0]    r_id,    n_id;       // id being visited
    logic               r_rd,    n_rd;       // job is a read
    logic [SA_W-1:0]    r_start, n_start;    // start of visited name
    logic [FP_W-1:0]    r_len,   n_len;      // length of visited name
    logic [PB_AW:0]     r_idx,   n_idx;      // character index
    logic               r_out_v, n_out_v;
    t_item_out          r_out,   n_out;

    // memory ports
    logic               cs_we;
    logic [SA_W-1:0]    cs_waddr, cs_raddr;
    logic [7:0]         cs_wdata, cs_rdata;
    logic               ns_we;
    logic [NS_AW-1:0]   ns_waddr, ns_raddr;
    logic [SA_W-1:0]    ns_rdata;
    logic               pb_we;
    logic [PB_AW-1:0]   pb_waddr, pb_raddr;
    logic [7:0]         pb_rdata;

    logic               accept;
    logic [FP_W-1:0]    end_pos;
    logic [FP_W-1:0]    vis_len;
    logic [FP_W:0]      need;
    logic               idx_last_p;          // index reaches pending length
    logic               idx_last_r;          // index reaches visited length
    logic               id_last;
    logic               cnt_full;
    logic               acc_ovf;
    logic [PL_W-1:0]    acc_plen;

    nit_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_char_store (
        .i_clk(i_clk), .i_we(cs_we), .i_waddr(cs_waddr), .i_wdata(cs_wdata),
        .i_raddr(cs_raddr), .o_rdata(cs_rdata)
    );

    nit_ram #(.WIDTH(SA_W), .DEPTH(NS_D)) u_name_start (
        .i_clk(i_clk), .i_we(ns_we), .i_waddr(ns_waddr), .i_wdata(r_free[SA_W-1:0]),
        .i_raddr(ns_raddr), .o_rdata(ns_rdata)
    );

    nit_ram #(.WIDTH(8), .DEPTH(MAX_NAME_LEN)) u_pend_buf (
        .i_clk(i_clk), .i_we(pb_we), .i_waddr(pb_waddr), .i_wdata(i_item.char_in),
        .i_raddr(pb_raddr), .o_rdata(pb_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_out_v;
    assign o_result = r_out;

    // end of visited name: next start, or the free pointer for the newest name
    assign id_last    = (r_id == r_count);
    assign end_pos    = id_last ? r_free : {1'b0, ns_rdata};
    assign vis_len    = end_pos - {1'b0, r_start} - FP_W'(1);
    assign idx_last_p = ((r_idx + 1'b1) == r_plen);
    assign idx_last_r = ({{(FP_W-PL_W){1'b0}}, r_idx + 1'b1} == r_len);
    assign cnt_full   = (r_count >= ID_W'(MAX_NAMES));
    assign need       = {1'b0, r_free} + {{(FP_W+1-PL_W){1'b0}}, r_plen} + (FP_W+1)'(1);

    // pending length and overflow after buffering the accepted character
    assign acc_ovf  = r_ovf || (r_plen == PL_W'(MAX_NAME_LEN));
    assign acc_plen = (r_plen == PL_W'(MAX_NAME_LEN)) ? r_plen : r_plen + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.func == FN_READ) begin
                        if (i_item.name_id != '0 && i_item.name_id <= r_count) begin
                            n_state = S_NS0;
                        end
                    end else if (i_item.char_last && !acc_ovf) begin
                        n_state = (r_count == '0) ? S_ALLOC : S_NS0;
                    end
                end
            end
            S_NS0: n_state = S_NS1;
            S_NS1: n_state = S_NS2;
            S_NS2: begin
                if (r_rd) begin
                    n_state = S_RC0;
                end else if (vis_len == {{(FP_W-PL_W){1'b0}}, r_plen}) begin
                    n_state = S_CC0;
                end else begin
                    n_state = id_last ? S_ALLOC : S_NS0;
                end
            end
            S_CC0: n_state = S_CC1;
            S_CC1: begin
                if (cs_rdata != pb_rdata) begin
                    n_state = id_last ? S_ALLOC : S_NS0;
                end else if (idx_last_p) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CC0;
                end
            end
            S_ALLOC: begin
                if (cnt_full || need >= (FP_W+1)'(STORE_BYTES)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CP0;
                end
            end
            S_CP0: n_state = S_CP1;
            S_CP1: n_state = idx_last_p ? S_TERM : S_CP0;
            S_TERM: n_state = S_IDLE;
            S_RC0: n_state = S_RC1;
            S_RC1: n_state = idx_last_r ? S_IDLE : S_RC0;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory control and result beats
    always_comb begin
        n_count  = r_count;
        n_free   = r_free;
        n_plen   = r_plen;
        n_ovf    = r_ovf;
        n_id     = r_id;
        n_rd     = r_rd;
        n_start  = r_start;
        n_len    = r_len;
        n_idx    = r_idx;
        n_out_v  = 1'b0;
        n_out    = r_out;
        cs_we    = 1'b0;
        cs_waddr = r_free[SA_W-1:0] + SA_W'(r_idx);
        cs_wdata = pb_rdata;
        cs_raddr = r_start + SA_W'(r_idx);
        ns_we    = 1'b0;
        ns_waddr = NS_AW'(r_count + 1'b1);
        ns_raddr = NS_AW'(r_id);
        pb_we    = 1'b0;
        pb_waddr = r_plen[PB_AW-1:0];
        pb_raddr = r_idx[PB_AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.func == FN_READ) begin
                        n_rd = 1'b1;
                        n_id = i_item.name_id;
                        if (i_item.name_id == '0 || i_item.name_id > r_count) begin
                            n_out_v = 1'b1;
                            n_out   = '{result_id: '0, char_out: '0, out_last: 1'b1,
                                        status: ST_BADID};
                        end
                    end else begin
                        // buffer the character unless the name is already too long
                        pb_we  = (r_plen != PL_W'(MAX_NAME_LEN));
                        n_plen = acc_plen;
                        n_ovf  = acc_ovf;
                        n_rd   = 1'b0;
                        n_id   = ID_W'(1);
                        if (i_item.char_last && acc_ovf) begin
                            n_out_v = 1'b1;
                            n_out   = '{result_id: '0, char_out: '0, out_last: 1'b1,
                                        status: ST_FULL};
                            n_plen  = '0;
                            n_ovf   = 1'b0;
                        end
                    end
                end
            end
            S_NS0: ns_raddr = NS_AW'(r_id);
            S_NS1: begin
                n_start  = ns_rdata;
                ns_raddr = NS_AW'(r_id + 1'b1);
            end
            S_NS2: begin
                n_len = vis_len;
                n_idx = '0;
                if (!r_rd && vis_len != {{(FP_W-PL_W){1'b0}}, r_plen}) begin
                    n_id = r_id + 1'b1;
                end
            end
            S_CC0: ;
            S_CC1: begin
                if (cs_rdata != pb_rdata) begin
                    n_id = r_id + 1'b1;
                end else if (idx_last_p) begin
                    n_out_v = 1'b1;
                    n_out   = '{result_id: r_id, char_out: '0, out_last: 1'b1,
                                status: ST_EXISTING};
                    n_plen  = '0;
                    n_ovf   = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ALLOC: begin
                n_idx = '0;
                if (cnt_full || need >= (FP_W+1)'(STORE_BYTES)) begin
                    n_out_v = 1'b1;
                    n_out   = '{result_id: '0, char_out: '0, out_last: 1'b1,
                                status: ST_FULL};
                    n_plen  = '0;
                    n_ovf   = 1'b0;
                end else begin
                    ns_we = 1'b1;
                end
            end
            S_CP0: ;
            S_CP1: begin
                cs_we = 1'b1;
                n_idx = r_idx + 1'b1;
            end
            S_TERM: begin
                // zero byte closes the stored name
                cs_we    = 1'b1;
                cs_waddr = r_free[SA_W-1:0] + SA_W'(r_plen);
                cs_wdata = '0;
                n_count  = r_count + 1'b1;
                n_free   = r_free + FP_W'(r_plen) + FP_W'(1);
                n_out_v  = 1'b1;
                n_out    = '{result_id: r_count + 1'b1, char_out: '0, out_last: 1'b1,
                             status: ST_NEW};
                n_plen   = '0;
                n_ovf    = 1'b0;
            end
            S_RC0: ;
            S_RC1: begin
                n_out_v = 1'b1;
                n_out   = '{result_id: r_id, char_out: cs_rdata, out_last: idx_last_r,
                            status: ST_EXISTING};
                n_idx   = r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_free  <= '0;
            r_plen  <= '0;
            r_ovf   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_free  <= n_free;
            r_plen  <= n_plen;
            r_ovf   <= n_ovf;
            r_out_v <= n_out_v;
        end
        r_id    <= n_id;
        r_rd    <= n_rd;
        r_start <= n_start;
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end
endmodule

@@ hdl/nit_ram.sv @@
// generic simple dual-port ram with registered read
module nit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ tb/sv/testbench.sv @@
// testbench: directed and random checking of the name interning table against a predictor
`timescale 1ns / 100ps

module testbench;
    import nit_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_item_in  i_item;
    logic      o_strobe;
    t_item_out o_result;

    name_interning_table_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // predictor copy of the table
    logic [7:0] shadow_chars [STORE_BYTES];
    int unsigned shadow_start [NS_D];
    int unsigned shadow_count;
    int unsigned shadow_free;
    logic [7:0] partial_name [MAX_NAME_LEN];
    int unsigned partial_len;
    bit          partial_long;

    t_item_out expected_beats [$];
    int unsigned fail_count;
    int unsigned beats_seen;
    int unsigned items_sent;
    int unsigned cycle_count;

    // name a random pool of short names so that repeats and matches happen
    logic [7:0] pool_chars [8][MAX_NAME_LEN + 4];
    int unsigned pool_len [8];

    function automatic int unsigned stored_length(int unsigned id);
        int unsigned stop;
        stop = (id < shadow_count) ? shadow_start[id + 1] : shadow_free;
        return stop - shadow_start[id] - 1;
    endfunction

    // works out the result beats of one accepted item
    task automatic predict_beats(input t_item_in it);
        t_item_out r;
        int unsigned hit;
        int unsigned len;
        bit          same;
        if (it.func == FN_INTERN) begin
            if (partial_len < MAX_NAME_LEN) begin
                partial_name[partial_len] = it.char_in;
                partial_len++;
            end else begin
                partial_long = 1'b1;
            end
            if (!it.char_last) return;
            r = '0;
            r.out_last = 1'b1;
            hit = 0;
            if (partial_long) begin
                r.status = ST_FULL;
            end else begin
                for (int unsigned id = 1; id <= shadow_count && hit == 0; id++) begin
                    if (stored_length(id) == partial_len) begin
                        same = 1'b1;
                        for (int unsigned k = 0; k < partial_len; k++)
                            if (shadow_chars[shadow_start[id] + k] != partial_name[k])
                                same = 1'b0;
                        if (same) hit = id;
                    end
                end
                if (hit != 0) begin
                    r.result_id = hit[6:0];
                    r.status = ST_EXISTING;
                end else if (shadow_count >= MAX_NAMES ||
                             shadow_free + partial_len + 1 >= STORE_BYTES) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_count++;
                    shadow_start[shadow_count] = shadow_free;
                    for (int unsigned k = 0; k < partial_len; k++)
                        shadow_chars[shadow_free + k] = partial_name[k];
                    shadow_chars[shadow_free + partial_len] = 8'd0;
                    shadow_free += partial_len + 1;
                    r.result_id = shadow_count[6:0];
                    r.status = ST_NEW;
                end
            end
            partial_len = 0;
            partial_long = 1'b0;
            expected_beats.push_back(r);
        end else begin
            if (it.name_id == 0 || it.name_id > shadow_count) begin
                r = '0;
                r.out_last = 1'b1;
                r.status = ST_BADID;
                expected_beats.push_back(r);
                return;
            end
            len = stored_length(it.name_id);
            for (int unsigned k = 0; k < len; k++) begin
                r.result_id = it.name_id;
                r.char_out = shadow_chars[shadow_start[it.name_id] + k];
                r.out_last = (k + 1 == len);
                r.status = ST_EXISTING;
                expected_beats.push_back(r);
            end
        end
    endtask

    // result beats are compared at the edge that accepts them
    always @(posedge i_clk) begin
        t_item_out want;
        if (i_rst_n && o_strobe) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat %p", o_result);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_result.result_id !== want.result_id) begin
                    $error("result_id expected %0d actual %0d", want.result_id,
                           o_result.result_id);
                    fail_count++;
                end
                if (o_result.char_out !== want.char_out) begin
                    $error("char_out expected %0d actual %0d", want.char_out,
                           o_result.char_out);
                    fail_count++;
                end
                if (o_result.out_last !== want.out_last) begin
                    $error("out_last expected %0d actual %0d", want.out_last,
                           o_result.out_last);
                    fail_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_result.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 4000000) begin
            $display("name_interning_table_unit verification failed");
            $finish;
        end
    end

    bit quiet_stretch;

    // hand one item over, with an optional idle gap first
    task automatic send_item(input t_item_in it);
        if (!quiet_stretch) begin
            while ($urandom_range(99) < 17) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_beats(it);
        items_sent++;
    endtask

    function automatic t_item_in mk_char(logic [7:0] c, logic lst);
        t_item_in it;
        it.func = FN_INTERN;
        it.char_in = c;
        it.char_last = lst;
        it.name_id = 7'($urandom);
        return it;
    endfunction

    function automatic t_item_in mk_read(logic [6:0] id);
        t_item_in it;
        it.func = FN_READ;
        it.char_in = 8'($urandom);
        it.char_last = 1'($urandom);
        it.name_id = id;
        return it;
    endfunction

    // directed rows, expected beat typed in where obvious
    typedef struct {
        t_item_in  item;
        bit        has_known;
        t_item_out known;
    } t_row;

    t_row directed_rows [$];

    function automatic t_item_out beat_of(int unsigned id, int unsigned st);
        t_item_out r;
        r = '0;
        r.result_id = 7'(id);
        r.out_last = 1'b1;
        r.status = 2'(st);
        return r;
    endfunction

    task automatic add_row(input t_item_in it, input bit known, input t_item_out r);
        t_row row;
        row.item = it;
        row.has_known = known;
        row.known = r;
        directed_rows.push_back(row);
    endtask

    initial begin
        t_item_out none;
        int unsigned pick;
        int unsigned len;
        none = '0;
        fail_count = 0;
        beats_seen = 0;
        items_sent = 0;
        cycle_count = 0;
        partial_len = 0;
        partial_long = 1'b0;
        shadow_count = 0;
        shadow_free = 0;
        quiet_stretch = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bad ids on an empty table
        add_row(mk_read(7'd0), 1, beat_of(0, ST_BADID));
        add_row(mk_read(7'd127), 1, beat_of(0, ST_BADID));
        // single character names at the character extremes
        add_row(mk_char(8'hff, 1'b1), 1, beat_of(1, ST_NEW));
        add_row(mk_char(8'h01, 1'b1), 1, beat_of(2, ST_NEW));
        add_row(mk_char(8'hff, 1'b1), 1, beat_of(1, ST_EXISTING));
        // two character name with a read in the middle
        add_row(mk_char(8'h55, 1'b0), 0, none);
        add_row(mk_read(7'd1), 0, none);
        add_row(mk_char(8'haa, 1'b1), 1, beat_of(3, ST_NEW));
        add_row(mk_read(7'd3), 0, none);
        add_row(mk_read(7'd4), 1, beat_of(0, ST_BADID));
        add_row(mk_read(7'd64), 1, beat_of(0, ST_BADID));
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item);
            if (directed_rows[i].has_known && expected_beats.size() != 0 &&
                expected_beats[$] != directed_rows[i].known) begin
                $error("directed row %0d: predictor %p table %p", i, expected_beats[$],
                       directed_rows[i].known);
                fail_count++;
            end
        end
        // longest name that fits, then one character too long
        for (int k = 0; k < MAX_NAME_LEN; k++)
            send_item(mk_char(8'(k + 1), k == MAX_NAME_LEN - 1));
        send_item(mk_read(7'd4));
        for (int k = 0; k <= MAX_NAME_LEN; k++)
            send_item(mk_char(8'(k + 1), k == MAX_NAME_LEN));

        // random part: names from a small pool, fresh names, reads, some noise
        foreach (pool_len[p]) begin
            pool_len[p] = $urandom_range(1, 6);
            for (int k = 0; k < MAX_NAME_LEN + 4; k++)
                pool_chars[p][k] = 8'($urandom_range(1, 255));
        end
        for (int n = 0; n < 10; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                pick = $urandom_range(7);
                for (int k = 0; k < pool_len[pick]; k++)
                    send_item(mk_char(pool_chars[pick][k], k == pool_len[pick] - 1));
            end else if (pick < 70) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(30, 35)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_item(mk_char(8'($urandom_range(1, 255)), k == len - 1));
            end else begin
                send_item(mk_read(7'($urandom_range(0, shadow_count + 3))));
            end
        end
        // fill up the slots to reach the full case, back to back
        quiet_stretch = 1'b1;
        while (shadow_count < MAX_NAMES)
            send_item(mk_char(8'($urandom_range(1, 255)), 1'b1));
        quiet_stretch = 1'b0;
        send_item(mk_char(8'h7e, 1'b0));
        send_item(mk_char(8'h81, 1'b1));
        send_item(mk_read(7'd64));
        send_item(mk_read(7'd65));
        send_item(mk_char(8'hff, 1'b1));
        start <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("items accepted %0d, result beats checked %0d, names held %0d",
                 items_sent, beats_seen, shadow_count);
        $display("covered intern, existing, full, over-long, read and bad-id paths");
        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("name_interning_table_unit verification clean");
        end else begin
            $display("name_interning_table_unit verification failed");
        end
        $finish;
    end

endmodule
